// ===== hdl/velocity_frame_rotation_top_assert.svh =====
// ---------------------------------------------------------------------------
// velocity_frame_rotation_top_assert.svh
// Assertion macros for the velocity frame rotation block.
// ---------------------------------------------------------------------------
`ifndef VELOCITY_FRAME_ROTATION_TOP_ASSERT_SVH
`define VELOCITY_FRAME_ROTATION_TOP_ASSERT_SVH

// Checked only while out of reset.
`define VFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define VFR_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vfr_pkg.sv =====
// ---------------------------------------------------------------------------
// vfr_pkg
// Shared types, widths and the arctangent table of the rotation pipeline.
// ---------------------------------------------------------------------------
package vfr_pkg;

  localparam int DATA_BITS      = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS      = 8;
  localparam int STAGES         = 24;
  // vector after 2^FRAC_BITS scaling, quarter turn and CORDIC growth (~2.33x)
  localparam int XY_W           = DATA_BITS + FRAC_BITS + 3;
  localparam int Z_W            = 34;
  localparam int REG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int KGAIN_W        = 21;
  localparam int KSHIFT         = 20;
  localparam int GSHIFT         = FRAC_BITS + 8;

  localparam logic [REG_W-1:0]          GAIN_RESET = REG_W'(256);
  localparam logic signed [KGAIN_W-1:0] KGAIN_Q20  = KGAIN_W'(636751);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_GAIN    = 2'd0,
    CFG_HEADING_OFFSET = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] vel_x;
    logic signed [DATA_BITS-1:0] vel_y;
    logic [15:0]                 heading;
    logic [15:0]                 spin_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] rot_x;
    logic signed [DATA_BITS-1:0] rot_y;
    logic                        saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  // atan(2^-i) in turns * 2^32
  function automatic logic signed [Z_W-1:0] atan_turns(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(536870912);
      1:       v = Z_W'(316933406);
      2:       v = Z_W'(167458907);
      3:       v = Z_W'(85004756);
      4:       v = Z_W'(42667331);
      5:       v = Z_W'(21354465);
      6:       v = Z_W'(10679838);
      7:       v = Z_W'(5340245);
      8:       v = Z_W'(2670163);
      9:       v = Z_W'(1335087);
      10:      v = Z_W'(667544);
      11:      v = Z_W'(333772);
      12:      v = Z_W'(166886);
      13:      v = Z_W'(83443);
      14:      v = Z_W'(41722);
      15:      v = Z_W'(20861);
      16:      v = Z_W'(10430);
      17:      v = Z_W'(5215);
      18:      v = Z_W'(2608);
      19:      v = Z_W'(1304);
      20:      v = Z_W'(652);
      21:      v = Z_W'(326);
      22:      v = Z_W'(163);
      23:      v = Z_W'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/vfr_front.sv =====
// ---------------------------------------------------------------------------
// vfr_front
// Angle sum, quadrant split and exact quarter-turn pre-rotation.
// ---------------------------------------------------------------------------
module vfr_front #(
  parameter int ANGLE_BITS = vfr_pkg::ANGLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  vfr_pkg::in_beat_t        in_beat,
  input  logic [vfr_pkg::REG_W-1:0] heading_offset,
  output logic                     vld_r,
  output vfr_pkg::cordic_vec_t     vec_r
);
  import vfr_pkg::*;

  localparam int SUM_W = (ANGLE_BITS > 18) ? ANGLE_BITS : 18;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  logic [SUM_W-1:0]        sum;
  logic [ANGLE_BITS-1:0]   phi;
  logic [ANGLE_BITS-1:0]   ang;
  logic [ANGLE_BITS-1:0]   ang_bias;
  logic [ANGLE_BITS-1:0]   resid;
  quad_t                   quad;
  logic signed [XY_W-1:0]  x0;
  logic signed [XY_W-1:0]  y0;
  cordic_vec_t             vec_nxt;

  always_comb begin
    sum      = SUM_W'(in_beat.heading) + SUM_W'(heading_offset) + SUM_W'(in_beat.spin_angle);
    phi      = sum[ANGLE_BITS-1:0];
    ang      = -phi;
    ang_bias = ang + {3'b001, {(ANGLE_BITS-3){1'b0}}};
    quad     = quad_t'(ang_bias[ANGLE_BITS-1 -: 2]);
    resid    = ang - {ang_bias[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}};
    x0 = {{(XY_W-DATA_BITS-FRAC_BITS){in_beat.vel_x[DATA_BITS-1]}},
          in_beat.vel_x, {FRAC_BITS{1'b0}}};
    y0 = {{(XY_W-DATA_BITS-FRAC_BITS){in_beat.vel_y[DATA_BITS-1]}},
          in_beat.vel_y, {FRAC_BITS{1'b0}}};
    vec_nxt.z = {{(Z_W-32){resid[ANGLE_BITS-1]}}, resid, {(32-ANGLE_BITS){1'b0}}};
    unique case (quad)
      QUAD_0: begin
        vec_nxt.x = x0;
        vec_nxt.y = y0;
      end
      QUAD_1: begin
        vec_nxt.x = -y0;
        vec_nxt.y = x0;
      end
      QUAD_2: begin
        vec_nxt.x = -x0;
        vec_nxt.y = -y0;
      end
      QUAD_3: begin
        vec_nxt.x = y0;
        vec_nxt.y = -x0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

// ===== hdl/vfr_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// vfr_cordic_stage
// One registered CORDIC micro-rotation, shift fixed by IDX.
// ---------------------------------------------------------------------------
module vfr_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  vfr_pkg::cordic_vec_t vec_in,
  output logic                 vld_r,
  output vfr_pkg::cordic_vec_t vec_r
);
  import vfr_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_turns(IDX);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_vec_t            vec_nxt;

  always_comb begin
    dx = vec_in.y >>> IDX;
    dy = vec_in.x >>> IDX;
    if (!vec_in.z[Z_W-1]) begin
      vec_nxt.x = vec_in.x - dx;
      vec_nxt.y = vec_in.y + dy;
      vec_nxt.z = vec_in.z - ATAN;
    end else begin
      vec_nxt.x = vec_in.x + dx;
      vec_nxt.y = vec_in.y - dy;
      vec_nxt.z = vec_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

// ===== hdl/vfr_scale.sv =====
// ---------------------------------------------------------------------------
// vfr_scale
// CORDIC gain removal, output gain with rounding, saturation, output register.
// ---------------------------------------------------------------------------
module vfr_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic signed [vfr_pkg::XY_W-1:0] x_in,
  input  logic signed [vfr_pkg::XY_W-1:0] y_in,
  input  logic [vfr_pkg::REG_W-1:0]    gain,
  output logic                         vld_r,
  output vfr_pkg::out_beat_t           beat_r
);
  import vfr_pkg::*;

  localparam int PK_W = XY_W + KGAIN_W;
  localparam int GX_W = XY_W + REG_W + 1;

  localparam logic signed [GX_W-1:0] HI  = {{(GX_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [GX_W-1:0] LO  = {{(GX_W-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};
  localparam logic signed [GX_W-1:0] RND = {{(GX_W-GSHIFT){1'b0}}, 1'b1, {(GSHIFT-1){1'b0}}};

  // {clipped flag, value}
  function automatic logic [DATA_BITS:0] clip(input logic signed [GX_W-1:0] v);
    logic [DATA_BITS:0] res;
    priority if (v > HI) begin
      res = {1'b1, HI[DATA_BITS-1:0]};
    end else if (v < LO) begin
      res = {1'b1, LO[DATA_BITS-1:0]};
    end else begin
      res = {1'b0, v[DATA_BITS-1:0]};
    end
    return res;
  endfunction

  logic                   vld1_r, vld2_r;
  logic signed [PK_W-1:0] kx_r, ky_r;
  logic signed [PK_W-1:0] kx_nxt, ky_nxt;
  logic signed [XY_W-1:0] mx, my;
  logic signed [REG_W:0]  gain_s;
  logic signed [GX_W-1:0] gx_r, gy_r;
  logic signed [GX_W-1:0] gx_nxt, gy_nxt;
  logic signed [GX_W-1:0] sx, sy;
  logic [DATA_BITS:0]     cx, cy;
  out_beat_t              beat_nxt;

  // stage 1: times 636751 / 2^20
  always_comb begin
    kx_nxt = x_in * KGAIN_Q20;
    ky_nxt = y_in * KGAIN_Q20;
  end

  // stage 2: floor shift, times output gain
  always_comb begin
    mx     = $signed(kx_r[KSHIFT +: XY_W]);
    my     = $signed(ky_r[KSHIFT +: XY_W]);
    gain_s = $signed({1'b0, gain});
    gx_nxt = mx * gain_s;
    gy_nxt = my * gain_s;
  end

  // stage 3: round, shift, clip
  always_comb begin
    sx = (gx_r + RND) >>> GSHIFT;
    sy = (gy_r + RND) >>> GSHIFT;
    cx = clip(sx);
    cy = clip(sy);
    beat_nxt.rot_x     = $signed(cx[DATA_BITS-1:0]);
    beat_nxt.rot_y     = $signed(cy[DATA_BITS-1:0]);
    beat_nxt.saturated = cx[DATA_BITS] | cy[DATA_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld_r  <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kx_r   <= kx_nxt;
      ky_r   <= ky_nxt;
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      beat_r <= beat_nxt;
    end
  end

endmodule

// ===== hdl/velocity_frame_rotation_top.sv =====
// ---------------------------------------------------------------------------
// velocity_frame_rotation_top: rotates a velocity beat by -(heading+offset+spin)
// Pipeline: 1 angle/quadrant stage, 24 CORDIC stages, 3 scale stages.
// Throughput one beat per cycle while not stalled; an output stall with a valid result freezes the whole pipeline.
// Synchronous active-low reset clears valid bits; gain = 1.0, offset = 0.
// ---------------------------------------------------------------------------
`include "velocity_frame_rotation_top_assert.svh"

module velocity_frame_rotation_top #(
  parameter int ANGLE_BITS = vfr_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vfr_pkg::in_beat_t            in_beat,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output vfr_pkg::out_beat_t           out_beat,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [vfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vfr_pkg::REG_W-1:0]    cfg_wdata
);
  import vfr_pkg::*;

  localparam logic signed [DATA_BITS-1:0] ROT_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] ROT_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  // Config registers. The user must write them only while the pipeline is empty;
  // the block does not enforce it, so the front stage and the gain stage read them live.
  logic [REG_W-1:0] gain_r;
  logic [REG_W-1:0] offset_r;

  // Pipeline advance. Every stage moves together; the only hold point is the
  // output register when the sink stalls. A bubble in the output register
  // lets new beats flow even under out_stall.
  logic en;

  // valid bit and vector for each point of the CORDIC chain
  logic [STAGES:0] stg_vld;
  cordic_vec_t     stg_vec [STAGES+1];

  // some component of the output beat sits on a range limit
  logic at_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_GAIN:    gain_r   <= cfg_wdata;
        CFG_HEADING_OFFSET: offset_r <= cfg_wdata;
        default: ;  // index beyond the register list: dropped
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // angle sum, quadrant pick, exact quarter-turn rotation, Q15 -> x256
  vfr_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_beat        (in_beat),
    .heading_offset (offset_r),
    .vld_r          (stg_vld[0]),
    .vec_r          (stg_vec[0])
  );

  // one micro-rotation per stage, residual angle driven toward zero
  for (genvar g = 0; g < STAGES; g++) begin : g_cordic
    vfr_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_in (stg_vld[g]),
      .vec_in (stg_vec[g]),
      .vld_r  (stg_vld[g+1]),
      .vec_r  (stg_vec[g+1])
    );
  end

  // remove CORDIC gain, apply Q8.8 gain with rounding, clip; ends in the
  // output register that faces the sink
  vfr_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (stg_vld[STAGES]),
    .x_in   (stg_vec[STAGES].x),
    .y_in   (stg_vec[STAGES].y),
    .gain   (gain_r),
    .vld_r  (out_valid),
    .beat_r (out_beat)
  );

  assign at_limit = (out_beat.rot_x == ROT_MAX) || (out_beat.rot_x == ROT_MIN) ||
                    (out_beat.rot_y == ROT_MAX) || (out_beat.rot_y == ROT_MIN);

  // a held result must hold the whole pipeline, input included
  `VFR_ASSERT(a_stall_holds_input, out_valid && out_stall |-> in_stall, "input open under stall")
  // a clipped beat carries a range limit in at least one component
  `VFR_ASSERT(a_sat_at_limit, out_valid && out_beat.saturated |-> at_limit, "clip off limit")
  // reset empties the pipeline
  `VFR_ASSERT_NORST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: velocity frame rotation testbench
// Drives velocity commands through the rotation pipeline with random bursts
// and output back-pressure, predicts every rotated beat in integer CORDIC
// arithmetic and checks results in order across several gain/offset settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import vfr_pkg::*;

  // Indexes past the register list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int  ROT_STAGES = 24;
  localparam int  PIPE_DRAIN = 40;      // padded beyond the pipeline depth
  localparam int  PHASE_CMDS = 190;
  localparam int  NUM_PHASES = 8;

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the two registers, predicts each rotated beat at
  // input acceptance and checks results against the oldest prediction.
  // -------------------------------------------------------------------------
  class rotation_scoreboard;
    logic [REG_W-1:0] gain;
    logic [REG_W-1:0] offset;
    out_beat_t        pending_rot[$];
    int               mismatch_cnt;
    int               stray_cnt;
    longint           atan_q32[ROT_STAGES];

    function new();
      gain   = 16'd256;
      offset = 16'd0;
      mismatch_cnt = 0;
      stray_cnt    = 0;
      // atan(2^-i), turns scaled by 2^32
      atan_q32 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == CFG_OUTPUT_GAIN) gain = val;
      else if (idx == CFG_HEADING_OFFSET) offset = val;
    endfunction

    // CORDIC gain compensation, output gain with round-half-up, clip
    function logic signed [DATA_BITS-1:0] scale_clip(longint v, output bit clipped);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DATA_BITS - 1)) - 1;
      lo = -hi - 1;
      v = (v * 636751) >>> 20;
      v = (v * longint'(gain) + 32768) >>> 16;
      clipped = 1'b0;
      if (v > hi) begin
        clipped = 1'b1;
        v = hi;
      end else if (v < lo) begin
        clipped = 1'b1;
        v = lo;
      end
      return v[DATA_BITS-1:0];
    endfunction

    function out_beat_t rotate_command(in_beat_t cmd);
      longint      px, py, pz, tmp, dx, dy;
      logic [15:0] phi, neg_phi, resid;
      logic [16:0] qsum;
      logic [1:0]  quad;
      bit          clip_x, clip_y;
      out_beat_t   res;
      px = longint'($signed(cmd.vel_x)) * 256;
      py = longint'($signed(cmd.vel_y)) * 256;
      phi     = cmd.heading + offset + cmd.spin_angle;  // wraps on one turn
      neg_phi = 16'd0 - phi;
      qsum    = {1'b0, neg_phi} + 17'd8192;
      quad    = qsum[15:14];
      resid   = neg_phi - {quad, 14'd0};
      pz      = longint'($signed(resid)) * 65536;
      // exact quarter-turn pre-rotation, counterclockwise
      case (quad)
        2'd1: begin
          tmp = px; px = -py; py = tmp;
        end
        2'd2: begin
          px = -px; py = -py;
        end
        2'd3: begin
          tmp = px; px = py; py = -tmp;
        end
        default: ;
      endcase
      for (int i = 0; i < ROT_STAGES; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (pz >= 0) begin
          px -= dx; py += dy; pz -= atan_q32[i];
        end else begin
          px += dx; py -= dy; pz += atan_q32[i];
        end
      end
      res.rot_x     = scale_clip(px, clip_x);
      res.rot_y     = scale_clip(py, clip_y);
      res.saturated = clip_x | clip_y;
      return res;
    endfunction

    function void note_command(in_beat_t cmd);
      pending_rot.push_back(rotate_command(cmd));
    endfunction

    function void check_rotation(out_beat_t got);
      out_beat_t exp_rot;
      if (pending_rot.size() == 0) begin
        stray_cnt++;
        if (stray_cnt <= 10)
          $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $realtime,
                   got.rot_x, got.rot_y, got.saturated);
        return;
      end
      exp_rot = pending_rot.pop_front();
      if (got.rot_x !== exp_rot.rot_x || got.rot_y !== exp_rot.rot_y ||
          got.saturated !== exp_rot.saturated) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: mismatch exp x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                   $realtime, exp_rot.rot_x, exp_rot.rot_y, exp_rot.saturated,
                   got.rot_x, got.rot_y, got.saturated);
      end
    endfunction

    function int pending();
      return pending_rot.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup
  // -------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_beat;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  velocity_frame_rotation_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rotation_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; a clean run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Monitors: both channels are sampled at the edge, before any NBA updates.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_command(in_beat);
      if (out_valid && !out_stall) sb.check_rotation(out_beat);
    end
  end

  // -------------------------------------------------------------------------
  // Result-side back-pressure. Modes rotate at random intervals: no stall,
  // light random, heavy random, and a fixed duty pattern.
  // -------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // -------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // -------------------------------------------------------------------------
  int burst_left = 1;

  function automatic in_beat_t command(int vx, int vy, int hdg, int spin);
    in_beat_t c;
    c.vel_x      = vx[DATA_BITS-1:0];
    c.vel_y      = vy[DATA_BITS-1:0];
    c.heading    = hdg[15:0];
    c.spin_angle = spin[15:0];
    return c;
  endfunction

  // Velocity: mostly full range, now and then a corner value.
  function automatic logic [DATA_BITS-1:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return DATA_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // Angle: mostly uniform, sometimes right at an octant edge where the
  // quarter-turn selection flips.
  function automatic logic [15:0] rand_angle();
    logic [15:0] edge_pt;
    edge_pt = {3'($urandom_range(0, 7)), 13'd0};
    if ($urandom_range(0, 7) == 0)
      return edge_pt + 16'($urandom_range(0, 2)) - 16'd1;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic in_beat_t rand_command();
    in_beat_t c;
    c.vel_x      = rand_vel();
    c.vel_y      = rand_vel();
    c.heading    = rand_angle();
    c.spin_angle = rand_angle();
    return c;
  endfunction

  task automatic push_command(in_beat_t cmd);
    in_valid <= 1'b1;
    in_beat  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      // drop valid and wiggle the idle payload
      in_valid <= 1'b0;
      in_beat  <= rand_command();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop sending and hold until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Only called with the pipeline empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  in_beat_t         directed[$];
  logic [REG_W-1:0] phase_gain[NUM_PHASES];
  logic [REG_W-1:0] phase_offset[NUM_PHASES];
  int               leftover;
  int               fail_cnt;

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_OUTPUT_GAIN;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed set at reset settings (gain one, no offset): field corners,
    // every quadrant, octant edges, angle wrap and clipping.
    directed.push_back(command(0, 0, 0, 0));
    directed.push_back(command(32767, 0, 0, 0));
    directed.push_back(command(-32768, 0, 0, 0));
    directed.push_back(command(0, 32767, 0, 0));
    directed.push_back(command(0, -32768, 0, 0));
    directed.push_back(command(32767, -32768, 16384, 0));
    directed.push_back(command(-32768, 32767, 32768, 0));
    directed.push_back(command(12000, -7000, 49152, 0));
    directed.push_back(command(32767, 32767, 8192, 0));       // clips at 45 deg
    directed.push_back(command(-32768, -32768, 0, 57344));    // clips low
    directed.push_back(command(1000, -2000, 57344, 0));       // octant edge
    directed.push_back(command(1000, -2000, 57345, 0));
    directed.push_back(command(1000, -2000, 57343, 0));
    directed.push_back(command(-5000, 3000, 24576, 0));
    directed.push_back(command(-5000, 3000, 24575, 0));
    directed.push_back(command(12345, -23456, 65535, 1));     // sum wraps to zero
    directed.push_back(command(12345, -23456, 65535, 65535));
    directed.push_back(command(32767, -32768, 65535, 65535));
    directed.push_back(command(-1, -1, 40000, 30000));
    directed.push_back(command(1, 1, 0, 0));
    directed.push_back(command(-1, 1, 16384, 16384));
    directed.push_back(command(20000, 20000, 0, 0));
    foreach (directed[i]) push_command(directed[i]);
    drain();

    // Register settings per random phase; extremes included.
    phase_gain   = '{16'd0, 16'd65535, 16'd512, 16'd256,
                     16'($urandom_range(0, 65535)), 16'd128, 16'd65535, 16'd300};
    phase_offset = '{16'd0, 16'd65535, 16'd16384, 16'd8192,
                     16'($urandom_range(0, 65535)), 16'd0, 16'd32768, 16'd49151};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_OUTPUT_GAIN, phase_gain[ph]);
      write_reg(CFG_HEADING_OFFSET, phase_offset[ph]);
      if (ph == 3) begin
        // writes past the register list must not disturb anything
        write_reg(CFG_SPARE_2, 16'hffff);
        write_reg(CFG_SPARE_3, 16'h1234);
      end
      for (int n = 0; n < PHASE_CMDS; n++) begin
        push_command(rand_command());
        // mid-phase: hold off until the pipeline is fully drained
        if (n == PHASE_CMDS / 2 && ph % 3 == 1) drain();
      end
      drain();
    end

    repeat (PIPE_DRAIN) @(posedge clk);
    leftover = sb.pending();
    fail_cnt = sb.mismatch_cnt + sb.stray_cnt + leftover;
    if (fail_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vfr_pkg.sv
hdl/vfr_front.sv
hdl/vfr_cordic_stage.sv
hdl/vfr_scale.sv
hdl/velocity_frame_rotation_top.sv
dv/tb.sv
